// File: hdl/assert_macros.svh
// Assertion macros shared by the Rice decoder RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rice decoder check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rice decoder check failed");

`endif

// File: hdl/rcd_pkg.sv
// Shared types and constants for the Rice code bitstream decoder.
// Used by rcd_ctrl, rcd_datapath and rice_code_bitstream_decoder; no dependencies.
package rcd_pkg;

  localparam int BYTE_W    = 8;
  localparam int BIT_CNT_W = 3;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  localparam int K_W       = 4;
  localparam int REM_W     = 15;
  localparam int VALUE_W   = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RICE_K      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input byte
    logic step;      // decode one bit
    logic last_bit;  // the bit being decoded is bit 7 of the byte
    logic flush;     // release the held result as the last one of the byte
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic step_ok;     // a bit can be decoded without losing a result
    logic pend_valid;  // a decoded result is held back
    logic out_free;    // the output register can take a result
  } stat_t;

endpackage

// File: hdl/rcd_ctrl.sv
// Controller of the Rice decoder: sequences bits of one byte, then a flush.
// Depends on rcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rcd_pkg::stat_t stat,
  output rcd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  state_t state;
  logic [rcd_pkg::BIT_CNT_W-1:0] bit_cnt;

  // Accept a byte only between bytes
  assign s_tready = (state == ST_IDLE);

  // Drive commands
  always_comb begin
    cmd.load     = s_tvalid && s_tready;
    cmd.step     = (state == ST_RUN) && stat.step_ok;
    cmd.last_bit = (bit_cnt == rcd_pkg::LAST_BIT);
    cmd.flush    = (state == ST_FLUSH) && stat.out_free;
  end

  // Hold state and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          bit_cnt <= '0;
          if (cmd.load) state <= ST_RUN;
        end
        ST_RUN: begin
          if (cmd.step) begin
            bit_cnt <= bit_cnt + 1'b1;
            if (cmd.last_bit) state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          bit_cnt <= '0;
          if (!stat.pend_valid || stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CHK_SAME(a_idle_cnt_zero, state == ST_IDLE, bit_cnt == '0)
  `CHK_NEXT(a_flush_done, (state == ST_FLUSH) && (!stat.pend_valid || stat.out_free),
            state == ST_IDLE)

endmodule

// File: hdl/rcd_datapath.sv
// Datapath of the Rice decoder: config registers, code state, held and output results.
// Depends on rcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcd_datapath #(
  parameter int MAX_QUOTIENT = 255,
  parameter int MAX_RICE_K   = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input payload
  input  logic [rcd_pkg::BYTE_W-1:0]      s_tdata,
  input  logic                            s_tlast,
  // output channel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rcd_pkg::VALUE_W-1:0]     m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast,
  // controller link
  input  rcd_pkg::cmd_t                   cmd,
  output rcd_pkg::stat_t                  stat
);

  localparam int QW  = $clog2(MAX_QUOTIENT + 1);
  localparam int VW  = rcd_pkg::VALUE_W + 1;
  localparam logic [rcd_pkg::K_W:0] KMAX = (rcd_pkg::K_W + 1)'(MAX_RICE_K);

  // configuration registers
  logic [rcd_pkg::K_W-1:0] rice_k;
  logic                    signed_mode;

  // byte being decoded
  logic [rcd_pkg::BYTE_W-1:0] shreg;
  logic                       eos;

  // code state
  logic                    in_rem;
  logic [QW-1:0]           q;
  logic                    sat;
  logic [rcd_pkg::REM_W-1:0] rem;
  logic [rcd_pkg::K_W-1:0] rem_cnt;

  // held result, released once the next result or the end of the byte shows up
  logic                         pend_valid;
  logic [rcd_pkg::VALUE_W-1:0]  pend_value;
  logic                         pend_ovf;

  logic                         bit_in;
  logic [rcd_pkg::K_W-1:0]      k_eff;
  logic [rcd_pkg::REM_W-1:0]    rem_set;
  logic [rcd_pkg::K_W-1:0]      cnt_inc;
  logic                         emit_now;
  logic [rcd_pkg::REM_W-1:0]    rem_masked;
  logic [VW-1:0]                v;
  logic [rcd_pkg::VALUE_W-1:0]  value_new;
  logic                         out_free;
  logic                         push_emit;
  logic                         push_flush;

  assign cfg_ready = 1'b1;

  // Form the next bit's outcome and the value of a completing code
  always_comb begin
    bit_in     = shreg[0];
    k_eff      = ({1'b0, rice_k} > KMAX) ? KMAX[rcd_pkg::K_W-1:0] : rice_k;
    rem_set    = rem | (rcd_pkg::REM_W'(bit_in) << rem_cnt);
    cnt_inc    = rem_cnt + 1'b1;
    emit_now   = in_rem ? (cnt_inc >= k_eff) : (!bit_in && (k_eff == '0));
    rem_masked = (in_rem ? rem_set : '0) & ~({rcd_pkg::REM_W{1'b1}} << k_eff);
    v          = (VW'(q) << k_eff) | VW'(rem_masked);
    // zigzag: odd v gives ~(v >> 1), even v gives v >> 1
    value_new  = signed_mode ? (v[VW-1:1] ^ {rcd_pkg::VALUE_W{v[0]}})
                             : v[rcd_pkg::VALUE_W-1:0];
    out_free   = !m_tvalid || m_tready;
    push_emit  = cmd.step && emit_now && pend_valid;
    push_flush = cmd.flush && pend_valid;
  end

  assign stat.step_ok    = !(emit_now && pend_valid && !out_free);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // Write configuration registers; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      rice_k      <= '0;
      signed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rcd_pkg::REG_RICE_K) rice_k <= cfg_data[rcd_pkg::K_W-1:0];
      else if (cfg_index == rcd_pkg::REG_SIGNED_MODE) signed_mode <= cfg_data[0];
    end
  end

  // Load the byte, then shift one bit out per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= s_tdata;
      eos   <= s_tlast;
    end else if (cmd.step) begin
      shreg <= shreg >> 1;
    end
  end

  // Advance the code state one bit; clear it at a completed code or end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rem  <= 1'b0;
      q       <= '0;
      sat     <= 1'b0;
      rem     <= '0;
      rem_cnt <= '0;
    end else if (cmd.step) begin
      if (emit_now || (cmd.last_bit && eos)) begin
        in_rem  <= 1'b0;
        q       <= '0;
        sat     <= 1'b0;
        rem     <= '0;
        rem_cnt <= '0;
      end else if (in_rem) begin
        rem     <= rem_set;
        rem_cnt <= cnt_inc;
      end else if (bit_in) begin
        if (q == QW'(MAX_QUOTIENT)) sat <= 1'b1;
        else q <= q + 1'b1;
      end else begin
        in_rem  <= 1'b1;
        rem     <= '0;
        rem_cnt <= '0;
      end
    end
  end

  // Hold the newest result until it is known whether it ends the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && emit_now) begin
      pend_valid <= 1'b1;
    end else if (push_flush) begin
      pend_valid <= 1'b0;
    end
    if (cmd.step && emit_now) begin
      pend_value <= value_new;
      pend_ovf   <= sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_emit || push_flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (push_emit || push_flush) begin
      m_tdata <= pend_value;
      m_tuser <= pend_ovf;
      m_tlast <= push_flush;
    end
  end

  `CHK_SAME(a_no_result_lost, push_emit, out_free)
  `CHK_SAME(a_rem_cnt_range, in_rem, rem_cnt != {rcd_pkg::K_W{1'b1}})

endmodule

// File: hdl/rice_code_bitstream_decoder.sv
// Top level of the Rice code bitstream decoder.
// Depends on rcd_pkg, rcd_ctrl and rcd_datapath.
//
// Usage:
//   Input stream (s_*): one coded byte per transaction in s_tdata, decoded
//   bit 0 first; s_tlast marks the last byte of a stream, after which any
//   partial code is dropped and decoding starts afresh.
//   Output stream (m_*): one decoded value per transaction; m_tuser flags a
//   saturated quotient and m_tlast marks the last value caused by a byte.
//   Configuration (cfg_*): index 0 writes rice_k, index 1 writes signed_mode;
//   other indexes are ignored. Write only while the decoder is idle.
// Timing:
//   After acceptance, the eight bits of a byte pass one per step through the
//   code state; then a flush state and the idle state follow, and the next
//   byte is accepted in idle. A value enters the output register when the next
//   value of its byte completes, or at the flush for the last one, and is
//   offered from the following cycle. A stalled receiver holds the output
//   register; bit decoding waits only when a new value completes while one is
//   held and the register is full.
// Reset (rst, synchronous): clears config, code state, held result, controller state and output valid.
module rice_code_bitstream_decoder #(
  parameter int MAX_QUOTIENT = 255,
  parameter int MAX_RICE_K   = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rcd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] stream_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rcd_pkg::VALUE_W-1:0]     m_tdata,   // [23:0] value (signed when signed_mode is set, else unsigned)
  output logic                            m_tuser,   // [0] overflow
  output logic                            m_tlast
);

  rcd_pkg::cmd_t  cmd;
  rcd_pkg::stat_t stat;

  rcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcd_datapath #(
    .MAX_QUOTIENT (MAX_QUOTIENT),
    .MAX_RICE_K   (MAX_RICE_K)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: test/rice_code_bitstream_decoder_test.sv
// Self-checking testbench for rice_code_bitstream_decoder: streams coded bytes,
// predicts every decoded value in-line and checks the output stream against it.
// Depends on rcd_pkg and the rice_code_bitstream_decoder RTL.
module rice_code_bitstream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUOTIENT_LIMIT = 255;
  localparam int K_LIMIT        = 15;
  localparam int SETTLE_CYCLES  = 30;
  localparam int QUIET_LIMIT    = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 6;

  // Indexes the decoder does not decode as registers
  localparam logic [rcd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rcd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [rcd_pkg::BYTE_W-1:0] data;
    logic                       eos;
  } coded_byte_t;

  typedef struct packed {
    logic [rcd_pkg::VALUE_W-1:0] value;
    logic                        overflow;
    logic                        last;
  } decoded_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rcd_pkg::BYTE_W-1:0]     s_tdata = '0;   // [7:0] stream_byte
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rcd_pkg::VALUE_W-1:0]    m_tdata;        // [23:0] value (signed when signed_mode is set, else unsigned)
  logic                           m_tuser;        // [0] overflow
  logic                           m_tlast;

  coded_byte_t pending_bytes[$];
  decoded_t    pending_values[$];
  logic        code_bits[$];
  int          queued_bytes = 0;
  int          idle_pct = 16;
  logic        byte_taken = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Predictor copy of the registers and the code state
  logic [rcd_pkg::K_W-1:0]   k_setting = '0;
  logic                      zigzag_on = 1'b0;
  logic                      reading_rem = 1'b0;
  int                        ones_count = 0;
  logic                      ones_capped = 1'b0;
  logic [rcd_pkg::REM_W-1:0] rem_word = '0;
  int                        rem_len = 0;

  rice_code_bitstream_decoder #(
    .MAX_QUOTIENT(QUOTIENT_LIMIT),
    .MAX_RICE_K  (K_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decode one byte bit by bit and queue the values it completes
  function automatic void decode_byte(input logic [rcd_pkg::BYTE_W-1:0] b, input logic eos);
    decoded_t    found[8];
    int          n;
    int          i;
    int          k_eff;
    logic        done;
    logic [63:0] v;
    logic [63:0] r;
    n = 0;
    k_eff = (k_setting > K_LIMIT) ? K_LIMIT : k_setting;
    for (i = 0; i < 8; i++) begin
      done = 1'b0;
      if (!reading_rem) begin
        if (b[i]) begin
          if (ones_count < QUOTIENT_LIMIT) ones_count++;
          else ones_capped = 1'b1;
        end else if (k_eff == 0) begin
          done = 1'b1;
        end else begin
          reading_rem = 1'b1;
          rem_word = '0;
          rem_len = 0;
        end
      end else begin
        rem_word[rem_len] = b[i];
        rem_len++;
        done = (rem_len >= k_eff);
      end
      if (done) begin
        v = (64'(ones_count) << k_eff) | (64'(rem_word) & ((64'd1 << k_eff) - 64'd1));
        if (zigzag_on) r = v[0] ? (64'd0 - ((v + 64'd1) >> 1)) : (v >> 1);
        else r = v;
        found[n].value = r[rcd_pkg::VALUE_W-1:0];
        found[n].overflow = ones_capped;
        found[n].last = 1'b0;
        n++;
        reading_rem = 1'b0;
        ones_count = 0;
        ones_capped = 1'b0;
        rem_word = '0;
        rem_len = 0;
      end
    end
    for (i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_values.push_back(found[i]);
    end
    // End of stream drops any partial code
    if (eos) begin
      reading_rem = 1'b0;
      ones_count = 0;
      ones_capped = 1'b0;
      rem_word = '0;
      rem_len = 0;
    end
  endfunction

  function automatic void add_byte(input logic [rcd_pkg::BYTE_W-1:0] data, input logic eos);
    coded_byte_t item;
    item.data = data;
    item.eos = eos;
    pending_bytes.push_back(item);
    queued_bytes++;
  endfunction

  // Append one code: q ones, the closing zero, then nbits remainder bits
  function automatic void push_code(input int q, input int rem, input int nbits);
    int i;
    for (i = 0; i < q; i++) code_bits.push_back(1'b1);
    code_bits.push_back(1'b0);
    for (i = 0; i < nbits; i++) code_bits.push_back(rem[i]);
  endfunction

  // Pad the bit store to whole bytes with random bits and queue the bytes
  function automatic void pack_stream(input logic eos);
    logic [rcd_pkg::BYTE_W-1:0] b;
    int i;
    if (eos && code_bits.size() == 0) code_bits.push_back(1'($urandom_range(1)));
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(1)));
    while (code_bits.size() > 0) begin
      for (i = 0; i < 8; i++) b[i] = code_bits.pop_front();
      add_byte(b, eos && (code_bits.size() == 0));
    end
  endfunction

  task automatic write_reg(input logic [rcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == rcd_pkg::REG_RICE_K) k_setting = data[rcd_pkg::K_W-1:0];
    else if (idx == rcd_pkg::REG_SIGNED_MODE) zigzag_on = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every byte is in and every value is out, then let the decoder settle
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_tvalid || pending_values.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive the byte stream and the receiver's ready
  always @(negedge clk) begin : drive
    coded_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
      if (!s_tvalid || byte_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tlast <= nxt.eos;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict on each accepted byte, check each accepted value, watch for a hang
  always @(posedge clk) begin : observe
    decoded_t want;
    if (rst) begin
      byte_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      byte_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_values.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected value transaction: value %h overflow %b last %b",
                     m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = pending_values.pop_front();
          if (m_tdata !== want.value || m_tuser !== want.overflow || m_tlast !== want.last) begin
            if (mismatches < REPORT_LIMIT)
              $display("value mismatch: expected %h/%b/%b, got %h/%b/%b (value/overflow/last)",
                       want.value, want.overflow, want.last, m_tdata, m_tuser, m_tlast);
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : stimulus
    int   k_plan[PHASES];
    int   sign_plan[PHASES];
    int   ph;
    int   k;
    int   q;
    int   sel;
    int   nbits;
    int   start;
    int   target;
    int   long_left;
    logic sgn;
    k_plan = '{0, 15, 5, 1, -1, 15};
    sign_plan = '{1, 0, 0, 1, -1, 1};
    long_left = 2;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings (k = 0, unsigned): eight codes in one byte, a long run
    // of ones across bytes, and a partial code dropped at end of stream
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte(8'hF0, 1'b1);
    add_byte(8'h01, 1'b0);
    wait_idle();

    // Unused indexes are ignored, and only bit 0 of signed_mode is kept
    write_reg(REG_SPARE_A, 4'hF);
    write_reg(REG_SPARE_B, 4'h0);
    write_reg(rcd_pkg::REG_SIGNED_MODE, 4'hE);
    write_reg(rcd_pkg::REG_RICE_K, 4'hF);
    write_reg(rcd_pkg::REG_SIGNED_MODE, 4'h1);

    // Widest remainder, all ones then all zeros, then codes cut by end of stream
    add_byte(8'hFE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_idle();

    // Leave a code inside its remainder, then shrink k before the next bit
    write_reg(rcd_pkg::REG_RICE_K, 4'h3);
    add_byte(8'h0E, 1'b0);
    add_byte(8'h10, 1'b0);
    wait_idle();
    write_reg(rcd_pkg::REG_RICE_K, 4'h1);
    add_byte(8'h01, 1'b0);
    add_byte(8'hC3, 1'b1);
    wait_idle();

    // Random phases: mostly well-formed codes, some noise and cut streams
    for (ph = 0; ph < PHASES; ph++) begin
      k = (k_plan[ph] < 0) ? $urandom_range(K_LIMIT) : k_plan[ph];
      sgn = (sign_plan[ph] < 0) ? 1'($urandom_range(1)) : 1'(sign_plan[ph]);
      write_reg(rcd_pkg::REG_RICE_K, 4'(k));
      write_reg(rcd_pkg::REG_SIGNED_MODE, {3'($urandom_range(7)), sgn});
      idle_pct = (ph == 2) ? 0 : 16;
      target = (ph == 2) ? 70 * 8 : 45 * 8;
      start = queued_bytes;

      // Saturated quotient with a full remainder: the widest values
      if (ph == 1) push_code(300, (1 << k) - 1, k);
      if (ph == 5) push_code(270, (1 << k) - 1, k);

      while ((queued_bytes - start) * 8 + code_bits.size() < target) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          q = $urandom_range(6);
          if (long_left > 0 && $urandom_range(39) == 0) begin
            long_left--;
            case ($urandom_range(3))
              0: q = QUOTIENT_LIMIT - 1;
              1: q = QUOTIENT_LIMIT;
              2: q = QUOTIENT_LIMIT + 1;
              default: q = $urandom_range(QUOTIENT_LIMIT + 45, QUOTIENT_LIMIT + 2);
            endcase
          end
          push_code(q, $urandom() & ((1 << k) - 1), k);
        end else if (sel < 80) begin
          repeat (8) code_bits.push_back(1'($urandom_range(1)));
        end else if (sel < 88) begin
          pack_stream(1'b1);
        end else begin
          nbits = $urandom_range(k);
          push_code($urandom_range(6), $urandom(), nbits);
          pack_stream(1'b1);
        end
      end

      // End the phase either cleanly or in the middle of a code
      if ($urandom_range(1)) begin
        pack_stream(1'b1);
      end else begin
        push_code($urandom_range(3), $urandom(), (k > 0) ? $urandom_range(k - 1) : 0);
        pack_stream(1'b0);
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: rice_code_bitstream_decoder.f
+incdir+hdl
hdl/rcd_pkg.sv
hdl/rcd_ctrl.sv
hdl/rcd_datapath.sv
hdl/rice_code_bitstream_decoder.sv
test/rice_code_bitstream_decoder_test.sv
